[design/ccud_pkg.sv]
package ccud_pkg;

   // field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int ACTION_W = 2;
   localparam int UNIT_W   = 3;
   localparam int ERR_W    = 2;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DOWN = 2'd2;

   // unit codes
   localparam logic [UNIT_W-1:0] UNIT_SECOND = 3'd0;
   localparam logic [UNIT_W-1:0] UNIT_MINUTE = 3'd1;
   localparam logic [UNIT_W-1:0] UNIT_HOUR   = 3'd2;
   localparam logic [UNIT_W-1:0] UNIT_DAY    = 3'd3;
   localparam logic [UNIT_W-1:0] UNIT_MONTH  = 3'd4;
   localparam logic [UNIT_W-1:0] UNIT_YEAR   = 3'd5;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LOAD  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_LIMIT = 2'd2;

   // limits
   localparam logic [YEAR_W-1:0]   YEAR_MIN   = 14'd1000;
   localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
   localparam logic [MONTH_W-1:0]  MONTH_MIN  = 4'd1;
   localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
   localparam logic [DAY_W-1:0]    DAY_MIN    = 5'd1;
   localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
   localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
   localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;

   // reset values
   localparam logic [YEAR_W-1:0]   YEAR_RST   = 14'd2020;
   localparam logic [MONTH_W-1:0]  MONTH_RST  = 4'd7;
   localparam logic [DAY_W-1:0]    DAY_RST    = 5'd20;
   localparam logic [HOUR_W-1:0]   HOUR_RST   = 5'd15;
   localparam logic [MINUTE_W-1:0] MINUTE_RST = 6'd15;
   localparam logic [SECOND_W-1:0] SECOND_RST = 6'd15;

   // divide by 100 as multiply by reciprocal, exact for 14-bit years
   localparam int          DIV100_MUL   = 5243;
   localparam int          DIV100_SHIFT = 19;
   localparam int          DIV100_PW    = YEAR_W + 13;
   localparam int          CENT_W       = DIV100_PW - DIV100_SHIFT;

   // per-cell control
   typedef struct packed {
      logic en;        // transaction accepted this cycle
      logic up;        // carry in / step up
      logic dn;        // borrow in / step down
      logic hold;      // keep value instead of wrapping at a limit
      logic ld_en;     // take the load value
      logic clamp_en;  // saturate to clamp value
   } ccud_ctl_type;

   // one result
   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [ERR_W-1:0]    err;
   } ccud_rsp_type;

   // gregorian leap rule without a divider
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [DIV100_PW-1:0] prod;
      logic [CENT_W-1:0]    cent;
      logic [YEAR_W:0]      cent_x100;
      logic                 whole_cent;
      prod       = DIV100_PW'(y) * DIV100_PW'(DIV100_MUL);
      cent       = prod[DIV100_PW-1:DIV100_SHIFT];
      cent_x100  = ((YEAR_W+1)'(cent) << 6) + ((YEAR_W+1)'(cent) << 5)
                 + ((YEAR_W+1)'(cent) << 2);
      whole_cent = (cent_x100 == {1'b0, y});
      return (y[1:0] == 2'd0) && (!whole_cent || (cent[1:0] == 2'd0));
   endfunction

   // month length, 31 for a month code outside the year
   function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                input logic [YEAR_W-1:0] y);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[design/ccud_cell.sv]
module ccud_cell import ccud_pkg::*; #(
   parameter int           W   = SECOND_W,
   parameter logic [W-1:0] RST = '0
) (
   input  logic         clock,
   input  logic         reset,
   input  ccud_ctl_type ctl,
   input  logic [W-1:0] lo,
   input  logic [W-1:0] hi,
   input  logic [W-1:0] wrap_val,
   input  logic [W-1:0] ld_val,
   input  logic [W-1:0] clamp_val,
   output logic [W-1:0] cur,
   output logic [W-1:0] nxt,
   output logic         carry,
   output logic         borrow
);

   logic [W-1:0] cnt_ff;
   logic [W-1:0] cnt_in;
   logic [W-1:0] step_val;

   // carry and borrow to the next cell up
   assign carry  = ctl.up && (cnt_ff >= hi);
   assign borrow = ctl.dn && (cnt_ff <= lo);

   // load, step or hold
   always_comb begin
      step_val = cnt_ff;
      if (ctl.ld_en) begin
         step_val = ld_val;
      end else if (ctl.up) begin
         if (cnt_ff >= hi) begin
            step_val = ctl.hold ? cnt_ff : lo;
         end else begin
            step_val = cnt_ff + W'(1);
         end
      end else if (ctl.dn) begin
         if (cnt_ff <= lo) begin
            step_val = ctl.hold ? cnt_ff : wrap_val;
         end else begin
            step_val = cnt_ff - W'(1);
         end
      end
   end

   // saturate after a month or year change
   assign cnt_in = (ctl.clamp_en && (step_val > clamp_val)) ? clamp_val : step_val;
   assign nxt    = cnt_in;
   assign cur    = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= RST;
      end else if (ctl.en) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

[design/ccud_out.sv]
module ccud_out import ccud_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ccud_rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ccud_rsp_type rsp_data
);

   logic         out_v_ff, out_v_in;
   logic         skid_v_ff, skid_v_in;
   ccud_rsp_type out_ff, out_in;
   ccud_rsp_type skid_ff, skid_in;
   logic         pop;

   assign pop       = out_v_ff && !rsp_stall;
   assign full      = skid_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // two-entry output queue: output register plus skid
   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (pop) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (out_v_ff && !pop) begin
            skid_in   = push_data;
            skid_v_in = 1'b1;
         end else begin
            out_in   = push_data;
            out_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // skid holds data only behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry without output entry");

   // no push lands while the queue is full
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !pop |=> skid_v_ff && $stable(skid_ff))
      else $error("skid entry lost or overwritten");

endmodule

[design/calendar_clock_up_down.sv]
// Calendar clock: keeps year (1000..9999), month, day, hour, minute and second.
// Input channel req_*: one transaction either loads all six fields
// (req_action load) or steps the unit named by req_unit up or down by one,
// rippling carries and borrows through a chain of six counter cells with
// month lengths and the gregorian leap rule.
// Result channel rsp_*: one transaction per input transaction, carrying the
// date and time after it and an error code (0 ok, 1 load field rejected,
// 2 year limit reached, year held).
// The result is registered in the output queue, behind any result held by rsp_stall.
// Throughput: one transaction per cycle while req_stall is low; the whole
// carry chain is combinational and the state registers update at acceptance.
// A two-entry output queue sits in front of rsp_*: while rsp_stall is high
// up to two results wait, and req_stall rises only when both are held.
// Reset (synchronous, active high) sets 2020-07-20 15:15:15 and empties
// the output queue.
module calendar_clock_up_down import ccud_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [UNIT_W-1:0]   req_unit,
   input  logic [YEAR_W-1:0]   req_load_year,
   input  logic [MONTH_W-1:0]  req_load_month,
   input  logic [DAY_W-1:0]    req_load_day,
   input  logic [HOUR_W-1:0]   req_load_hour,
   input  logic [MINUTE_W-1:0] req_load_minute,
   input  logic [SECOND_W-1:0] req_load_second,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [YEAR_W-1:0]   rsp_cur_year,
   output logic [MONTH_W-1:0]  rsp_cur_month,
   output logic [DAY_W-1:0]    rsp_cur_day,
   output logic [HOUR_W-1:0]   rsp_cur_hour,
   output logic [MINUTE_W-1:0] rsp_cur_minute,
   output logic [SECOND_W-1:0] rsp_cur_second,
   output logic [ERR_W-1:0]    rsp_error_code
);

   logic         q_full;
   logic         acc;
   logic         is_ld, is_up, is_dn;
   logic         unit_ok;
   logic         mon_yr_step;

   ccud_ctl_type sec_ctl, min_ctl, hr_ctl, day_ctl, mon_ctl, yr_ctl;

   logic [SECOND_W-1:0] sec_cur, sec_nxt;
   logic [MINUTE_W-1:0] min_cur, min_nxt;
   logic [HOUR_W-1:0]   hr_cur, hr_nxt;
   logic [DAY_W-1:0]    day_cur, day_nxt;
   logic [MONTH_W-1:0]  mon_cur, mon_nxt;
   logic [YEAR_W-1:0]   yr_cur, yr_nxt;

   logic sec_c, sec_b, min_c, min_b, hr_c, hr_b, day_c, day_b;
   logic mon_c, mon_b, yr_c, yr_b;

   logic                ly_ok, lm_ok, ld_ok, lh_ok, lmi_ok, ls_ok;
   logic [YEAR_W-1:0]   ld_year_eff;
   logic [MONTH_W-1:0]  ld_month_eff;
   logic [MONTH_W-1:0]  prev_month;
   logic [DAY_W-1:0]    day_hi, day_wrap, day_clamp;
   logic [ERR_W-1:0]    err;
   ccud_rsp_type        rsp_new, rsp_q;

   // input handshake
   assign req_stall = q_full;
   assign acc       = req_valid && !q_full;
   assign unit_ok   = (req_unit <= UNIT_YEAR);
   assign is_ld     = acc && (req_action == ACT_LOAD);
   assign is_up     = acc && (req_action == ACT_UP) && unit_ok;
   assign is_dn     = acc && (req_action == ACT_DOWN) && unit_ok;

   // load checks, in field order
   assign ly_ok        = (req_load_year >= YEAR_MIN) && (req_load_year <= YEAR_MAX);
   assign lm_ok        = (req_load_month >= MONTH_MIN) && (req_load_month <= MONTH_MAX);
   assign ld_year_eff  = ly_ok ? req_load_year : yr_cur;
   assign ld_month_eff = lm_ok ? req_load_month : mon_cur;
   assign ld_ok        = (req_load_day >= DAY_MIN)
                       && (req_load_day <= days_in(ld_month_eff, ld_year_eff));
   assign lh_ok        = (req_load_hour <= HOUR_MAX);
   assign lmi_ok       = (req_load_minute <= MINUTE_MAX);
   assign ls_ok        = (req_load_second <= SECOND_MAX);

   // day limits from the current, previous and next month
   assign prev_month = (mon_cur <= MONTH_MIN) ? MONTH_MAX : mon_cur - MONTH_W'(1);
   assign day_hi     = days_in(mon_cur, yr_cur);
   assign day_wrap   = days_in(prev_month, yr_cur);
   assign day_clamp  = days_in(mon_nxt, yr_nxt);

   // day saturates on a direct month or year step; a day carry or borrow lands in range
   assign mon_yr_step = (is_up || is_dn)
                      && ((req_unit == UNIT_MONTH) || (req_unit == UNIT_YEAR));

   // cell controls: carries ripple from second to year
   assign sec_ctl = '{en: acc, up: is_up && (req_unit == UNIT_SECOND),
                      dn: is_dn && (req_unit == UNIT_SECOND), hold: 1'b0,
                      ld_en: is_ld && ls_ok, clamp_en: 1'b0};
   assign min_ctl = '{en: acc, up: (is_up && (req_unit == UNIT_MINUTE)) || sec_c,
                      dn: (is_dn && (req_unit == UNIT_MINUTE)) || sec_b, hold: 1'b0,
                      ld_en: is_ld && lmi_ok, clamp_en: 1'b0};
   assign hr_ctl  = '{en: acc, up: (is_up && (req_unit == UNIT_HOUR)) || min_c,
                      dn: (is_dn && (req_unit == UNIT_HOUR)) || min_b, hold: 1'b0,
                      ld_en: is_ld && lh_ok, clamp_en: 1'b0};
   assign mon_ctl = '{en: acc, up: (is_up && (req_unit == UNIT_MONTH)) || day_c,
                      dn: (is_dn && (req_unit == UNIT_MONTH)) || day_b, hold: 1'b0,
                      ld_en: is_ld && lm_ok, clamp_en: 1'b0};
   assign yr_ctl  = '{en: acc, up: (is_up && (req_unit == UNIT_YEAR)) || mon_c,
                      dn: (is_dn && (req_unit == UNIT_YEAR)) || mon_b, hold: 1'b1,
                      ld_en: is_ld && ly_ok, clamp_en: 1'b0};
   assign day_ctl = '{en: acc, up: (is_up && (req_unit == UNIT_DAY)) || hr_c,
                      dn: (is_dn && (req_unit == UNIT_DAY)) || hr_b, hold: 1'b0,
                      ld_en: is_ld && ld_ok, clamp_en: mon_yr_step};

   // the chain of cells
   ccud_cell #(.W(SECOND_W), .RST(SECOND_RST)) u_sec (
      .clock(clock), .reset(reset), .ctl(sec_ctl),
      .lo('0), .hi(SECOND_MAX), .wrap_val(SECOND_MAX),
      .ld_val(req_load_second), .clamp_val('0),
      .cur(sec_cur), .nxt(sec_nxt), .carry(sec_c), .borrow(sec_b));

   ccud_cell #(.W(MINUTE_W), .RST(MINUTE_RST)) u_min (
      .clock(clock), .reset(reset), .ctl(min_ctl),
      .lo('0), .hi(MINUTE_MAX), .wrap_val(MINUTE_MAX),
      .ld_val(req_load_minute), .clamp_val('0),
      .cur(min_cur), .nxt(min_nxt), .carry(min_c), .borrow(min_b));

   ccud_cell #(.W(HOUR_W), .RST(HOUR_RST)) u_hr (
      .clock(clock), .reset(reset), .ctl(hr_ctl),
      .lo('0), .hi(HOUR_MAX), .wrap_val(HOUR_MAX),
      .ld_val(req_load_hour), .clamp_val('0),
      .cur(hr_cur), .nxt(hr_nxt), .carry(hr_c), .borrow(hr_b));

   ccud_cell #(.W(DAY_W), .RST(DAY_RST)) u_day (
      .clock(clock), .reset(reset), .ctl(day_ctl),
      .lo(DAY_MIN), .hi(day_hi), .wrap_val(day_wrap),
      .ld_val(req_load_day), .clamp_val(day_clamp),
      .cur(day_cur), .nxt(day_nxt), .carry(day_c), .borrow(day_b));

   ccud_cell #(.W(MONTH_W), .RST(MONTH_RST)) u_mon (
      .clock(clock), .reset(reset), .ctl(mon_ctl),
      .lo(MONTH_MIN), .hi(MONTH_MAX), .wrap_val(MONTH_MAX),
      .ld_val(req_load_month), .clamp_val('0),
      .cur(mon_cur), .nxt(mon_nxt), .carry(mon_c), .borrow(mon_b));

   ccud_cell #(.W(YEAR_W), .RST(YEAR_RST)) u_yr (
      .clock(clock), .reset(reset), .ctl(yr_ctl),
      .lo(YEAR_MIN), .hi(YEAR_MAX), .wrap_val(YEAR_MAX),
      .ld_val(req_load_year), .clamp_val('0),
      .cur(yr_cur), .nxt(yr_nxt), .carry(yr_c), .borrow(yr_b));

   // error code
   always_comb begin
      err = ERR_OK;
      if (is_ld && !(ly_ok && lm_ok && ld_ok && lh_ok && lmi_ok && ls_ok)) begin
         err = ERR_LOAD;
      end else if (yr_c || yr_b) begin
         err = ERR_LIMIT;
      end
   end

   assign rsp_new = '{year: yr_nxt, month: mon_nxt, day: day_nxt, hour: hr_nxt,
                      minute: min_nxt, second: sec_nxt, err: err};

   // result queue
   ccud_out u_out (
      .clock(clock), .reset(reset), .push(acc), .push_data(rsp_new),
      .full(q_full), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_q));

   assign rsp_cur_year   = rsp_q.year;
   assign rsp_cur_month  = rsp_q.month;
   assign rsp_cur_day    = rsp_q.day;
   assign rsp_cur_hour   = rsp_q.hour;
   assign rsp_cur_minute = rsp_q.minute;
   assign rsp_cur_second = rsp_q.second;
   assign rsp_error_code = rsp_q.err;

   // after every accepted transaction rsp_valid is high in the next cycle
   a_acc_to_rsp: assert property (@(posedge clock) disable iff (reset)
      acc |=> rsp_valid)
      else $error("accepted transaction produced no result");

   // the year never leaves its range
   a_year_range: assert property (@(posedge clock) disable iff (reset)
      (yr_cur >= YEAR_MIN) && (yr_cur <= YEAR_MAX))
      else $error("year out of range");

   // the month never leaves its range
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (mon_cur >= MONTH_MIN) && (mon_cur <= MONTH_MAX))
      else $error("month out of range");

   // time of day stays in range and day never drops below its minimum
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (sec_cur <= SECOND_MAX) && (min_cur <= MINUTE_MAX) && (hr_cur <= HOUR_MAX)
      && (day_cur >= DAY_MIN))
      else $error("time field out of range");

   // year limit only on a step that leaves the year unchanged
   a_limit_holds: assert property (@(posedge clock) disable iff (reset)
      acc && (err == ERR_LIMIT) |-> !is_ld && (yr_nxt == yr_cur))
      else $error("year limit flagged but year moved");

endmodule
